>>> design/tlpc_pkg.sv
// shared constants, codes and types of the traffic light phase controller
// no dependencies
package tlpc_pkg;

    localparam int HISTORY_DEPTH_DEF = 128;
    localparam int COUNT_BITS_DEF    = 8;

    localparam int KIND_W  = 2;
    localparam int DIR_W   = 2;
    localparam int LEN_W   = 8;
    localparam int SUM_W   = 15;
    localparam int EFF_W   = 17;
    localparam int GREEN_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 16;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERT_GREEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VERT  = 2'd2;

    localparam logic [GREEN_W-1:0] GREEN_RESET = 16'd30;
    localparam logic [EFF_W-1:0]   EFF_ONE     = 17'h10000;
    localparam logic [SUM_W-1:0]   SUM_MAX     = 15'h7fff;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              vert_axis;
        logic              full;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic             granted;
        logic             vertical_green;
        logic [SUM_W-1:0] sum_v;
        logic [SUM_W-1:0] sum_h;
        logic [EFF_W-1:0] avg_v;
        logic [EFF_W-1:0] avg_h;
    } t_result;

endpackage

>>> design/tlpc_req_if.sv
// input channel of the controller: handshake plus item fields
// depends on tlpc_pkg
interface tlpc_req_if;
    import tlpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [DIR_W-1:0]  from_direction;
    logic              out_road_full;
    logic [LEN_W-1:0]  window_length;

    modport source (output valid, req_type, from_direction, out_road_full, window_length,
                    input ready);
    modport sink   (input valid, req_type, from_direction, out_road_full, window_length,
                    output ready);
endinterface

>>> design/tlpc_res_if.sv
// result channel of the controller: handshake plus result fields
// depends on tlpc_pkg
interface tlpc_res_if;
    import tlpc_pkg::*;
    logic             valid;
    logic             ready;
    logic             granted;
    logic             vertical_green;
    logic [SUM_W-1:0] sum_vertical_crossed;
    logic [SUM_W-1:0] sum_horizontal_crossed;
    logic [EFF_W-1:0] avg_vertical_eff;
    logic [EFF_W-1:0] avg_horizontal_eff;

    modport source (output valid, granted, vertical_green, sum_vertical_crossed,
                    sum_horizontal_crossed, avg_vertical_eff, avg_horizontal_eff,
                    input ready);
    modport sink   (input valid, granted, vertical_green, sum_vertical_crossed,
                    sum_horizontal_crossed, avg_vertical_eff, avg_horizontal_eff,
                    output ready);
endinterface

>>> design/tlpc_front.sv
// front end: takes input transactions and classifies them into commands
// depends on tlpc_pkg and tlpc_req_if
module tlpc_front (
    tlpc_req_if.sink        i_req,
    input  logic            i_q_full,
    output logic            o_push,
    output tlpc_pkg::t_cmd  o_cmd
);
    import tlpc_pkg::*;

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    always_comb begin
        o_cmd.kind      = i_req.req_type;
        // top and bottom approaches belong to the vertical axis
        o_cmd.vert_axis = !i_req.from_direction[1];
        o_cmd.full      = i_req.out_road_full;
        o_cmd.len       = i_req.window_length;
    end
endmodule

>>> design/tlpc_fifo.sv
// two-entry command queue between front and back
// depends on tlpc_pkg
module tlpc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlpc_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tlpc_pkg::t_cmd  o_cmd
);
    import tlpc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

>>> design/tlpc_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module tlpc_div #(
    parameter int DVW = 25,
    parameter int DSW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quotient
);
    localparam int CW = $clog2(DVW + 1);

    logic [DVW-1:0] r_quo;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_dsr;
    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic [DSW:0]   n_trial;
    logic           n_ge;

    assign n_trial    = {r_rem, r_quo[DVW-1]};
    assign n_ge       = (n_trial >= {1'b0, r_dsr});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DVW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVW-2:0], n_ge};
            r_rem <= n_ge ? DSW'(n_trial - {1'b0, r_dsr}) : n_trial[DSW-1:0];
        end
    end
endmodule

>>> design/tlpc_back.sv
// back end: light phase, per-tick counters, history ring and query engine
// depends on tlpc_pkg, tlpc_res_if and tlpc_div
module tlpc_back #(
    parameter int DEPTH = tlpc_pkg::HISTORY_DEPTH_DEF,
    parameter int CNT_W = tlpc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tlpc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_q_valid,
    input  tlpc_pkg::t_cmd                  i_q_cmd,
    output logic                            o_pop,
    tlpc_res_if.source                      o_res
);
    import tlpc_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (FW > LEN_W) ? FW : LEN_W;
    localparam int ESW   = EFF_W + LEN_W;
    localparam int DVW   = (CNT_W + 16 > ESW) ? CNT_W + 16 : ESW;
    localparam int DSW   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int REC_W = 1 + CNT_W + EFF_W;
    localparam int SAW   = ((SUM_W > CNT_W) ? SUM_W : CNT_W) + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TDIV = 3'd1;
    localparam logic [2:0] ST_QRD  = 3'd2;
    localparam logic [2:0] ST_QDV  = 3'd3;
    localparam logic [2:0] ST_QDH  = 3'd4;

    logic [2:0]         r_state;
    logic [GREEN_W-1:0] r_vg;
    logic [GREEN_W-1:0] r_hg;
    logic               r_phase;
    logic [GREEN_W-1:0] r_ticks;
    logic [CNT_W-1:0]   r_cross;
    logic [CNT_W-1:0]   r_elig;
    logic [AW-1:0]      r_head;
    logic [FW-1:0]      r_fill;
    logic [REC_W-1:0]   r_mem [DEPTH];
    logic [REC_W-1:0]   r_rdata;
    logic [AW-1:0]      r_raddr;
    logic               r_rv;
    logic [LEN_W-1:0]   r_n;
    logic [LEN_W-1:0]   r_i;
    logic [SUM_W-1:0]   r_sv;
    logic [SUM_W-1:0]   r_sh;
    logic [ESW-1:0]     r_ev;
    logic [ESW-1:0]     r_eh;
    logic [EFF_W-1:0]   r_avg_v;
    logic               r_ov;
    t_result            r_res;

    logic               n_slot_free;
    logic               n_tick_fire;
    logic [EFF_W-1:0]   n_tick_eff;
    logic               n_phase;
    logic [GREEN_W-1:0] n_ticks;
    logic               n_elig;
    logic [LEN_W-1:0]   n_len;
    logic               n_walk_done;
    logic               n_div_start;
    logic [DVW-1:0]     n_dividend;
    logic [DSW-1:0]     n_divisor;
    logic               div_done;
    logic [DVW-1:0]     div_quo;
    logic               n_res_we;
    t_result            n_res;
    logic               n_rec_ph;
    logic [CNT_W-1:0]   n_rec_cr;
    logic [EFF_W-1:0]   n_rec_ef;
    logic [SAW-1:0]     n_sv_add;
    logic [SAW-1:0]     n_sh_add;

    assign n_slot_free = !r_ov || o_res.ready;
    assign o_pop       = (r_state == ST_IDLE) && i_q_valid && n_slot_free;
    assign n_elig      = (i_q_cmd.vert_axis == r_phase);
    assign n_len       = (CMPW'(i_q_cmd.len) < CMPW'(r_fill)) ? i_q_cmd.len
                                                                : LEN_W'(r_fill);
    assign n_walk_done = (r_state == ST_QRD) && (r_i == r_n) && !r_rv;

    // tick completes at once when nothing was eligible, else after the division
    assign n_tick_fire = (o_pop && i_q_cmd.kind == KIND_TICK && r_elig == '0)
                         || (r_state == ST_TDIV && div_done);
    assign n_tick_eff  = (r_state == ST_TDIV) ? div_quo[EFF_W-1:0] : EFF_ONE;
    assign n_phase     = (r_ticks <= GREEN_W'(1)) ? ~r_phase : r_phase;
    assign n_ticks     = (r_ticks <= GREEN_W'(1)) ? (n_phase ? r_vg : r_hg)
                                                  : r_ticks - GREEN_W'(1);

    assign n_div_start = (o_pop && i_q_cmd.kind == KIND_TICK && r_elig != '0)
                         || n_walk_done || (r_state == ST_QDV && div_done);

    always_comb begin
        n_dividend = DVW'({r_cross, 16'h0000});
        n_divisor  = DSW'(r_elig);
        if (r_state == ST_QRD) begin
            n_dividend = DVW'(r_ev);
            n_divisor  = DSW'(r_n);
        end else if (r_state == ST_QDV) begin
            n_dividend = DVW'(r_eh);
            n_divisor  = DSW'(r_n);
        end
    end

    tlpc_div #(.DVW(DVW), .DSW(DSW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // history record: green axis, its crossings and its efficiency
    assign {n_rec_ph, n_rec_cr, n_rec_ef} = r_rdata;
    assign n_sv_add = SAW'(r_sv) + (n_rec_ph ? SAW'(n_rec_cr) : SAW'(0));
    assign n_sh_add = SAW'(r_sh) + (n_rec_ph ? SAW'(0) : SAW'(n_rec_cr));

    always_comb begin
        n_res_we             = 1'b0;
        n_res                = '0;
        n_res.vertical_green = r_phase;
        if (n_tick_fire) begin
            n_res_we             = 1'b1;
            n_res.vertical_green = n_phase;
        end else if (o_pop && i_q_cmd.kind == KIND_REQ) begin
            n_res_we      = 1'b1;
            n_res.granted = n_elig && !i_q_cmd.full;
        end else if (o_pop && i_q_cmd.kind == KIND_QUERY) begin
            n_res_we = (n_len == '0);
        end else if (o_pop && i_q_cmd.kind != KIND_TICK) begin
            n_res_we = 1'b1;
        end else if (r_state == ST_QDH && div_done) begin
            n_res_we    = 1'b1;
            n_res.sum_v = r_sv;
            n_res.sum_h = r_sh;
            n_res.avg_v = r_avg_v;
            n_res.avg_h = div_quo[EFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vg    <= GREEN_RESET;
            r_hg    <= GREEN_RESET;
            r_phase <= 1'b1;
            r_ticks <= GREEN_RESET;
            r_cross <= '0;
            r_elig  <= '0;
            r_head  <= '0;
            r_fill  <= '0;
            r_rv    <= 1'b0;
            r_i     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (n_res_we) begin
                r_ov <= 1'b1;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VERT_GREEN: begin
                        r_vg <= i_cfg_data;
                    end
                    CFG_HORIZ_GREEN: begin
                        r_hg <= i_cfg_data;
                    end
                    CFG_START_VERT: begin
                        r_phase <= i_cfg_data[0];
                        r_ticks <= i_cfg_data[0] ? r_vg : r_hg;
                    end
                    default: begin
                    end
                endcase
            end

            if (n_tick_fire) begin
                r_head  <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                if (r_fill != FW'(DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
                r_cross <= '0;
                r_elig  <= '0;
                r_phase <= n_phase;
                r_ticks <= n_ticks;
            end

            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_q_cmd.kind)
                            KIND_TICK: begin
                                if (r_elig != '0) begin
                                    r_state <= ST_TDIV;
                                end
                            end
                            KIND_REQ: begin
                                if (n_elig) begin
                                    if (r_elig != CNT_MAX) begin
                                        r_elig <= r_elig + CNT_W'(1);
                                    end
                                    if (!i_q_cmd.full && r_cross != CNT_MAX) begin
                                        r_cross <= r_cross + CNT_W'(1);
                                    end
                                end
                            end
                            KIND_QUERY: begin
                                if (n_len != '0) begin
                                    r_state <= ST_QRD;
                                end
                                r_n  <= n_len;
                                r_i  <= '0;
                                r_rv <= 1'b0;
                                r_sv <= '0;
                                r_sh <= '0;
                                r_ev <= '0;
                                r_eh <= '0;
                                r_raddr <= (r_head == '0) ? AW'(DEPTH - 1)
                                                          : r_head - AW'(1);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TDIV: begin
                    if (div_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_QRD: begin
                    // one read issued per cycle, newest record first
                    if (r_i != r_n) begin
                        r_rv    <= 1'b1;
                        r_i     <= r_i + LEN_W'(1);
                        r_raddr <= (r_raddr == '0) ? AW'(DEPTH - 1) : r_raddr - AW'(1);
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        r_sv <= (n_sv_add > SAW'(SUM_MAX)) ? SUM_MAX : n_sv_add[SUM_W-1:0];
                        r_sh <= (n_sh_add > SAW'(SUM_MAX)) ? SUM_MAX : n_sh_add[SUM_W-1:0];
                        r_ev <= r_ev + ESW'(n_rec_ph ? n_rec_ef : EFF_ONE);
                        r_eh <= r_eh + ESW'(n_rec_ph ? EFF_ONE : n_rec_ef);
                    end
                    if (n_walk_done) begin
                        r_state <= ST_QDV;
                    end
                end
                ST_QDV: begin
                    if (div_done) begin
                        r_avg_v <= div_quo[EFF_W-1:0];
                        r_state <= ST_QDH;
                    end
                end
                ST_QDH: begin
                    if (div_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_tick_fire) begin
            r_mem[r_head] <= {r_phase, r_cross, n_tick_eff};
        end
        r_rdata <= r_mem[r_raddr];
        if (n_res_we) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid                  = r_ov;
    assign o_res.granted                = r_res.granted;
    assign o_res.vertical_green         = r_res.vertical_green;
    assign o_res.sum_vertical_crossed   = r_res.sum_v;
    assign o_res.sum_horizontal_crossed = r_res.sum_h;
    assign o_res.avg_vertical_eff       = r_res.avg_v;
    assign o_res.avg_horizontal_eff     = r_res.avg_h;
endmodule

>>> design/traffic_light_phase_controller_top.sv
// flow: a request or quiet tick goes through the queue and is answered in the result register;
// a tick with eligible traffic first runs the serial divider (DVW = max(COUNT_BITS+16, 25));
// a query for an n-record window first walks the ring (one ring read per cycle),
// then runs two serial divisions before its result is registered
// throughput: one item in flight in the back end; a two-entry queue keeps the front open
// reset: synchronous active low; phase vertical, 30 green ticks, empty history
module traffic_light_phase_controller_top #(
    parameter int HISTORY_DEPTH = tlpc_pkg::HISTORY_DEPTH_DEF,
    parameter int COUNT_BITS    = tlpc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tlpc_pkg::CFG_W-1:0]      i_cfg_data,
    tlpc_req_if.sink                        i_req,
    tlpc_res_if.source                      o_res
);
    import tlpc_pkg::*;

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;
    // queue to back
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // classify the incoming transaction
    tlpc_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // short queue so the front keeps accepting while a query runs
    tlpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // state, history ring, divider and result register
    tlpc_back #(
        .DEPTH (HISTORY_DEPTH),
        .CNT_W (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_pop      (q_pop),
        .o_res      (o_res)
    );
endmodule

>>> tb/sv/tb.sv
// self-checking testbench of the traffic light phase controller: it drives ticks,
// crossing requests and window queries and checks every result against its own predictor
// depends on tlpc_pkg, tlpc_req_if, tlpc_res_if and traffic_light_phase_controller_top
module tb;
    import tlpc_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;
    localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 260;     // longer than a full-window query
    localparam int HOLD_FROM = 1000;        // receiver hold-off window, in cycles
    localparam int HOLD_TO = 1400;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DIR_W-1:0]  dir;
        logic              full;
        logic [LEN_W-1:0]  len;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    tlpc_req_if req_ch ();
    tlpc_res_if res_ch ();

    traffic_light_phase_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // light state as the predictor sees it
    logic [GREEN_W-1:0] green_v, green_h;
    logic               start_v;
    logic               phase_v;
    logic [GREEN_W-1:0] ticks_left;
    int unsigned        crossed_cnt, eligible_cnt;
    int unsigned        hist_cross_v [DEPTH];
    int unsigned        hist_cross_h [DEPTH];
    int unsigned        hist_eff_v [DEPTH];
    int unsigned        hist_eff_h [DEPTH];
    int unsigned        ring_head, ring_fill;

    t_item   pending_items [$];
    t_result expected_results [$];
    t_item   offered;
    int      send_idle_pct, recv_idle_pct;
    int      mismatches;
    int      cycle_cnt;
    logic    recv_hold;

    // queue helpers: append at the tail, take from the head
    function automatic void add_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic t_item take_item();
        t_item it;
        it = pending_items[0];
        pending_items.delete(0);
        return it;
    endfunction

    function automatic void add_expect(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic t_result take_expect();
        t_result r;
        r = expected_results[0];
        expected_results.delete(0);
        return r;
    endfunction

    function automatic logic [GREEN_W-1:0] green_of(logic vert);
        return vert ? green_v : green_h;
    endfunction

    function automatic void restart_light();
        phase_v = start_v;
        ticks_left = green_of(start_v);
    endfunction

    // advance the light by one item and return what the block should answer
    function automatic t_result light_step(t_item it);
        t_result r;
        int unsigned eff, n, idx;
        longint unsigned sv, sh, ev, eh;
        r = '0;
        case (it.kind)
            KIND_TICK: begin
                eff = 65536;
                if (eligible_cnt != 0)
                    eff = 32'((longint'(crossed_cnt) << 16) / eligible_cnt);
                hist_cross_v[ring_head] = phase_v ? crossed_cnt : 0;
                hist_cross_h[ring_head] = phase_v ? 0 : crossed_cnt;
                hist_eff_v[ring_head] = phase_v ? eff : 65536;
                hist_eff_h[ring_head] = phase_v ? 65536 : eff;
                ring_head = (ring_head + 1) % DEPTH;
                if (ring_fill < DEPTH) ring_fill++;
                crossed_cnt = 0;
                eligible_cnt = 0;
                // a zero green time behaves like one tick
                if (ticks_left <= 1) begin
                    phase_v = ~phase_v;
                    ticks_left = green_of(phase_v);
                end else begin
                    ticks_left--;
                end
            end
            KIND_REQ: begin
                if ((it.dir < 2) == phase_v) begin
                    if (eligible_cnt < CNT_MAX) eligible_cnt++;
                    if (!it.full) begin
                        if (crossed_cnt < CNT_MAX) crossed_cnt++;
                        r.granted = 1'b1;
                    end
                end
            end
            KIND_QUERY: begin
                n = (it.len < ring_fill) ? it.len : ring_fill;
                sv = 0; sh = 0; ev = 0; eh = 0;
                for (int i = 0; i < n; i++) begin
                    idx = (ring_head + DEPTH - 1 - i) % DEPTH;
                    sv += hist_cross_v[idx];
                    sh += hist_cross_h[idx];
                    ev += hist_eff_v[idx];
                    eh += hist_eff_h[idx];
                end
                if (n != 0) begin
                    r.sum_v = (sv > SUM_MAX) ? SUM_MAX : sv[SUM_W-1:0];
                    r.sum_h = (sh > SUM_MAX) ? SUM_MAX : sh[SUM_W-1:0];
                    r.avg_v = EFF_W'(ev / n);
                    r.avg_h = EFF_W'(eh / n);
                end
            end
            default: ;  // unused kind leaves the light alone
        endcase
        r.vertical_green = phase_v;
        return r;
    endfunction

    // driver: takes pending items, predicts each transaction as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                add_expect(light_step(offered));
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = take_item();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= offered.kind;
                    req_ch.from_direction <= offered.dir;
                    req_ch.out_road_full <= offered.full;
                    req_ch.window_length <= offered.len;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering, fills the block
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        recv_hold <= (cycle_cnt >= HOLD_FROM && cycle_cnt < HOLD_TO);
    end

    // monitor: random ready, compares each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.granted = res_ch.granted;
                got.vertical_green = res_ch.vertical_green;
                got.sum_v = res_ch.sum_vertical_crossed;
                got.sum_h = res_ch.sum_horizontal_crossed;
                got.avg_v = res_ch.avg_vertical_eff;
                got.avg_h = res_ch.avg_horizontal_eff;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %p", got);
                end else begin
                    want = take_expect();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result differs: expected %p, got %p", want, got);
                    end
                end
            end
            res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_item mk(logic [KIND_W-1:0] k, int unsigned d = 0,
                                 int unsigned f = 0, int unsigned l = 0);
        t_item it;
        it.kind = k; it.dir = DIR_W'(d); it.full = f[0]; it.len = LEN_W'(l);
        return it;
    endfunction

    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0);
        // every accepted item has been answered here; the extra wait is only a margin
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_VERT_GREEN:  green_v = data;
            CFG_HORIZ_GREEN: green_h = data;
            CFG_START_VERT: begin
                start_v = data[0];
                restart_light();
            end
            default: ;
        endcase
    endtask

    // well-formed traffic: bursts of requests closed by a tick, queries and unused kinds mixed in
    task automatic queue_traffic(int n_items, int burst_max);
        int cnt, burst;
        cnt = 0;
        while (cnt < n_items) begin
            burst = $urandom_range(burst_max);
            for (int i = 0; i < burst; i++)
                add_item(mk(KIND_REQ, $urandom_range(3),
                            ($urandom_range(9) < 3) ? 1 : 0, $urandom));
            add_item(mk(KIND_TICK, $urandom, $urandom, $urandom));
            cnt += burst + 1;
            if ($urandom_range(9) < 2) begin
                add_item(mk(KIND_QUERY, $urandom, $urandom,
                            $urandom_range(9) < 7 ? $urandom_range(1, 16) : $urandom));
                cnt++;
            end
            if ($urandom_range(49) == 0) begin
                add_item(mk(KIND_UNUSED, $urandom, $urandom, $urandom));
                cnt++;
            end
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = KIND_TICK;
        req_ch.from_direction = '0;
        req_ch.out_road_full = 1'b0;
        req_ch.window_length = '0;
        res_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_VERT_GREEN;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        cycle_cnt = 0;
        recv_hold = 1'b0;
        mismatches = 0;
        send_idle_pct = 13;
        recv_idle_pct = 53;
        green_v = GREEN_RESET;
        green_h = GREEN_RESET;
        start_v = 1'b1;
        restart_light();
        crossed_cnt = 0;
        eligible_cnt = 0;
        ring_head = 0;
        ring_fill = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty history, every approach, full exit, quiet tick, window extremes
        add_item(mk(KIND_QUERY, 0, 0, 5));
        add_item(mk(KIND_QUERY, 3, 1, 0));
        add_item(mk(KIND_TICK));
        add_item(mk(KIND_REQ, 0, 0));
        add_item(mk(KIND_REQ, 1, 1));
        add_item(mk(KIND_REQ, 2, 0));
        add_item(mk(KIND_REQ, 3, 1));
        add_item(mk(KIND_REQ, 1, 0));
        add_item(mk(KIND_TICK, 3, 1, 255));
        add_item(mk(KIND_QUERY, 0, 0, 1));
        add_item(mk(KIND_QUERY, 0, 0, 255));
        add_item(mk(KIND_UNUSED, 3, 1, 255));
        add_item(mk(KIND_QUERY, 2, 1, 128));
        drain();

        // phase swaps on every tick, zero green time, horizontal start
        write_reg(CFG_VERT_GREEN, 16'd1);
        write_reg(CFG_HORIZ_GREEN, 16'd0);
        write_reg(CFG_START_VERT, 16'd0);
        queue_traffic(450, 12);
        drain();

        // receiver mostly ready now; the longest green times never swap
        send_idle_pct = 53;
        recv_idle_pct = 13;
        write_reg(CFG_VERT_GREEN, 16'hffff);
        write_reg(CFG_HORIZ_GREEN, 16'hffff);
        write_reg(CFG_START_VERT, 16'd1);
        queue_traffic(450, 12);
        drain();

        // no idling; one long burst on the green horizontal axis saturates the counters
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_VERT_GREEN, 16'd3);
        write_reg(CFG_HORIZ_GREEN, 16'd5);
        write_reg(CFG_START_VERT, 16'hfffe);
        for (int i = 0; i < 600; i++)
            add_item(mk(KIND_REQ, 2 + $urandom_range(1), ($urandom_range(9) == 0) ? 1 : 0));
        add_item(mk(KIND_TICK));
        add_item(mk(KIND_QUERY, 0, 0, 1));
        queue_traffic(450, 20);
        drain();

        if (mismatches == 0) begin
            $display("traffic_light_phase_controller_top: match");
        end else begin
            $display("traffic_light_phase_controller_top: mismatch");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin
        #40000000;
        $display("traffic_light_phase_controller_top: mismatch");
        $finish;
    end
endmodule
